[hdl/bta_pkg.sv]
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types, constants and helpers for the boundary tag heap allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

  // byte offsets wide enough for any tag sum without wrapping into range
  localparam int ADDR_W  = 35;
  localparam int REQ_W   = 17;
  localparam int FREE_W  = 16;
  localparam int CHUNK_W = 17;
  localparam int ASZ_W   = 18;
  localparam int GSZ_W   = 19;
  localparam int STAT_W  = 2;

  typedef logic [ADDR_W-1:0] addr_t;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // heap layout constants
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd4096;
  localparam logic [31:0]        INIT_CHUNK  = 32'd4096;
  localparam logic [31:0]        PROLOG_TAG  = 32'd9;
  localparam logic [31:0]        ALLOC_TAG   = 32'd1;
  localparam int                 INIT_BRK    = 4112;
  localparam int                 SMALL_BRK   = 16;
  localparam int                 MIN_BLOCK   = 16;
  localparam int                 ALIGN_BYTES = 8;
  localparam int                 FIRST_BP    = 8;

  typedef struct packed {
    logic                mode;
    logic [REQ_W-1:0]    request_bytes;
    logic [FREE_W-1:0]   freed_address;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [FREE_W-1:0]   payload_address;
  } out_t;

  // datapath operations, one per cycle
  typedef enum logic [5:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_DISP,
    OP_F_RH, OP_F_WH, OP_F_WF,
    OP_M_RPF, OP_M_RPH, OP_M_RPA, OP_M_RH, OP_M_RNH, OP_M_DEC,
    OP_M1_WH, OP_M1_RH, OP_M1_WF,
    OP_M2_WF, OP_M2_RP, OP_M2_WP,
    OP_M3_WF, OP_M3_WP,
    OP_A_RD, OP_A_CHK,
    OP_G_CALC, OP_G_WH, OP_G_WF, OP_G_WE,
    OP_P_RH, OP_P_W1, OP_P_RH2, OP_P_W2, OP_P_W3, OP_P_RN, OP_P_W4,
    OP_RES
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [STAT_W-1:0] stat;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic req_zero;
    logic bp_lt_brk;
    logic blk_zero;
    logic blk_fit;
    logic grow_ok;
    logic prev_alloc;
    logic next_alloc;
    logic split;
  } sts_t;

  // size field of a tag word as a byte count
  function automatic addr_t size_of(input logic [31:0] w);
    size_of = {3'b000, w[31:3], 3'b000};
  endfunction

endpackage

[hdl/boundary_tag_heap_allocator.sv]
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// First-fit heap allocator with boundary tags over a word store.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  input     start, busy, in_data           taken when start and not busy
//  result    out_valid, out_data            one-cycle strobe, no backpressure
//  config    cfg_valid, cfg_ready, cfg_data taken when valid and ready
//
//  after reset a clearing pass writes the whole heap image with busy high;
//  config writes are taken during it
//  free: a header read, header and footer writes, then a coalesce; allocate:
//  a first-fit search (one store read per block), then placement, with heap
//  growth and a coalesce first when no free block fits (full if it cannot)
//  one item at a time; the result strobe comes in the cycle busy drops
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator #(
  parameter int HEAP_WORDS = 16384
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bta_pkg::in_t                  in_data,
  output logic                          out_valid,
  output bta_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bta_pkg::CHUNK_W-1:0]   cfg_data
);

  bta_pkg::cmd_t cmd;
  bta_pkg::sts_t sts;

  // config is always taken
  assign cfg_ready = 1'b1;

  bta_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bta_dpath #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[hdl/bta_ctrl.sv]
// ----------------------------------------------------------------------------
// bta_ctrl
// Sequencer for clear, free, coalesce, first-fit walk, growth and placement.
// ----------------------------------------------------------------------------
module bta_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  bta_pkg::sts_t   sts,
  output bta_pkg::cmd_t   cmd
);

  localparam int NS = 35;

  typedef enum logic [NS-1:0] {
    S_CLR    = NS'(1) << 0,
    S_IDLE   = NS'(1) << 1,
    S_DISP   = NS'(1) << 2,
    S_F_RH   = NS'(1) << 3,
    S_F_WH   = NS'(1) << 4,
    S_F_WF   = NS'(1) << 5,
    S_M_RPF  = NS'(1) << 6,
    S_M_RPH  = NS'(1) << 7,
    S_M_RPA  = NS'(1) << 8,
    S_M_RH   = NS'(1) << 9,
    S_M_RNH  = NS'(1) << 10,
    S_M_DEC  = NS'(1) << 11,
    S_M1_WH  = NS'(1) << 12,
    S_M1_RH  = NS'(1) << 13,
    S_M1_WF  = NS'(1) << 14,
    S_M2_WF  = NS'(1) << 15,
    S_M2_RP  = NS'(1) << 16,
    S_M2_WP  = NS'(1) << 17,
    S_M3_WF  = NS'(1) << 18,
    S_M3_WP  = NS'(1) << 19,
    S_A_RD   = NS'(1) << 20,
    S_A_CHK  = NS'(1) << 21,
    S_G_CALC = NS'(1) << 22,
    S_G_WH   = NS'(1) << 23,
    S_G_WF   = NS'(1) << 24,
    S_G_WE   = NS'(1) << 25,
    S_P_RH   = NS'(1) << 26,
    S_P_W1   = NS'(1) << 27,
    S_P_RH2  = NS'(1) << 28,
    S_P_W2   = NS'(1) << 29,
    S_P_W3   = NS'(1) << 30,
    S_P_RN   = NS'(1) << 31,
    S_P_W4   = NS'(1) << 32,
    S_RES    = NS'(1) << 33,
    S_SPARE  = NS'(1) << 34
  } state_t;

  state_t                         state_r, state_nxt;
  logic [bta_pkg::STAT_W-1:0]     stat_r, stat_nxt;
  state_t                         merge_exit;

  assign busy = (state_r != S_IDLE);

  // where a finished coalesce continues
  assign merge_exit = sts.is_free ? S_RES : S_P_RH;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    stat_nxt  = stat_r;
    cmd.op    = bta_pkg::OP_NONE;
    cmd.stat  = stat_r;
    case (state_r)
      S_CLR: begin
        cmd.op = bta_pkg::OP_CLEAR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = bta_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.op   = bta_pkg::OP_DISP;
        stat_nxt = bta_pkg::ST_DONE;
        if (sts.is_free) begin
          state_nxt = S_F_RH;
        end else if (sts.req_zero) begin
          stat_nxt  = bta_pkg::ST_ZERO;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_F_RH:  begin cmd.op = bta_pkg::OP_F_RH;  state_nxt = S_F_WH;  end
      S_F_WH:  begin cmd.op = bta_pkg::OP_F_WH;  state_nxt = S_F_WF;  end
      S_F_WF:  begin cmd.op = bta_pkg::OP_F_WF;  state_nxt = S_M_RPF; end
      S_M_RPF: begin cmd.op = bta_pkg::OP_M_RPF; state_nxt = S_M_RPH; end
      S_M_RPH: begin cmd.op = bta_pkg::OP_M_RPH; state_nxt = S_M_RPA; end
      S_M_RPA: begin cmd.op = bta_pkg::OP_M_RPA; state_nxt = S_M_RH;  end
      S_M_RH:  begin cmd.op = bta_pkg::OP_M_RH;  state_nxt = S_M_RNH; end
      S_M_RNH: begin cmd.op = bta_pkg::OP_M_RNH; state_nxt = S_M_DEC; end
      // pick one of the four coalesce cases
      S_M_DEC: begin
        cmd.op = bta_pkg::OP_M_DEC;
        if (sts.prev_alloc && sts.next_alloc) state_nxt = merge_exit;
        else if (sts.prev_alloc)              state_nxt = S_M1_WH;
        else if (sts.next_alloc)              state_nxt = S_M2_WF;
        else                                  state_nxt = S_M3_WF;
      end
      S_M1_WH: begin cmd.op = bta_pkg::OP_M1_WH; state_nxt = S_M1_RH;    end
      S_M1_RH: begin cmd.op = bta_pkg::OP_M1_RH; state_nxt = S_M1_WF;    end
      S_M1_WF: begin cmd.op = bta_pkg::OP_M1_WF; state_nxt = merge_exit; end
      S_M2_WF: begin cmd.op = bta_pkg::OP_M2_WF; state_nxt = S_M2_RP;    end
      S_M2_RP: begin cmd.op = bta_pkg::OP_M2_RP; state_nxt = S_M2_WP;    end
      S_M2_WP: begin cmd.op = bta_pkg::OP_M2_WP; state_nxt = merge_exit; end
      S_M3_WF: begin cmd.op = bta_pkg::OP_M3_WF; state_nxt = S_M3_WP;    end
      S_M3_WP: begin cmd.op = bta_pkg::OP_M3_WP; state_nxt = merge_exit; end
      // first-fit walk, a read and a check per block
      S_A_RD: begin
        cmd.op    = bta_pkg::OP_A_RD;
        state_nxt = sts.bp_lt_brk ? S_A_CHK : S_G_CALC;
      end
      S_A_CHK: begin
        cmd.op = bta_pkg::OP_A_CHK;
        if (sts.blk_zero)     state_nxt = S_G_CALC;
        else if (sts.blk_fit) state_nxt = S_P_RH;
        else                  state_nxt = S_A_RD;
      end
      S_G_CALC: begin
        cmd.op = bta_pkg::OP_G_CALC;
        if (sts.grow_ok) begin
          state_nxt = S_G_WH;
        end else begin
          stat_nxt  = bta_pkg::ST_FULL;
          state_nxt = S_RES;
        end
      end
      S_G_WH:  begin cmd.op = bta_pkg::OP_G_WH;  state_nxt = S_G_WF;  end
      S_G_WF:  begin cmd.op = bta_pkg::OP_G_WF;  state_nxt = S_G_WE;  end
      S_G_WE:  begin cmd.op = bta_pkg::OP_G_WE;  state_nxt = S_M_RPF; end
      S_P_RH:  begin cmd.op = bta_pkg::OP_P_RH;  state_nxt = S_P_W1;  end
      S_P_W1:  begin cmd.op = bta_pkg::OP_P_W1;  state_nxt = S_P_RH2; end
      S_P_RH2: begin cmd.op = bta_pkg::OP_P_RH2; state_nxt = S_P_W2;  end
      S_P_W2: begin
        cmd.op    = bta_pkg::OP_P_W2;
        state_nxt = sts.split ? S_P_W3 : S_RES;
      end
      S_P_W3:  begin cmd.op = bta_pkg::OP_P_W3;  state_nxt = S_P_RN;  end
      S_P_RN:  begin cmd.op = bta_pkg::OP_P_RN;  state_nxt = S_P_W4;  end
      S_P_W4:  begin cmd.op = bta_pkg::OP_P_W4;  state_nxt = S_RES;   end
      S_RES: begin
        cmd.op    = bta_pkg::OP_RES;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      stat_r  <= bta_pkg::ST_DONE;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // a result cycle always hands back to idle
  a_res_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RES |=> state_r == S_IDLE)
    else $error("result not followed by idle");

  // no heap work is commanded while idle except taking an item
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (cmd.op == bta_pkg::OP_NONE || cmd.op == bta_pkg::OP_LOAD))
    else $error("work commanded while idle");

  // an accepted item always goes to dispatch
  a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == S_DISP)
    else $error("accepted item not dispatched");
`endif

endmodule

[hdl/bta_dpath.sv]
// ----------------------------------------------------------------------------
// bta_dpath
// Heap word store, tag arithmetic, break pointer and result register.
// ----------------------------------------------------------------------------
module bta_dpath #(
  parameter int HEAP_WORDS = 16384
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bta_pkg::in_t                  in_data,
  input  logic                          cfg_we,
  input  logic [bta_pkg::CHUNK_W-1:0]   cfg_data,
  input  bta_pkg::cmd_t                 cmd,
  output bta_pkg::sts_t                 sts,
  output logic                          out_valid,
  output bta_pkg::out_t                 out_data
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int BW = $clog2(HEAP_WORDS * 4 + 1);
  localparam bta_pkg::addr_t HEAP_BYTES = bta_pkg::ADDR_W'(HEAP_WORDS) << 2;
  localparam bit BIG_HEAP = (HEAP_WORDS * 4 >= bta_pkg::INIT_BRK);
  localparam int BRK_RESET = BIG_HEAP ? bta_pkg::INIT_BRK : bta_pkg::SMALL_BRK;
  localparam bta_pkg::addr_t A4  = bta_pkg::ADDR_W'(4);
  localparam bta_pkg::addr_t A8  = bta_pkg::ADDR_W'(8);

  // word store
  logic [31:0]     mem [HEAP_WORDS];
  logic [31:0]     q_r;
  logic            rd_oob_r;
  bta_pkg::addr_t  raddr, waddr, wval;
  logic            wreq, mem_we;
  logic [AW-1:0]   r_idx, w_idx;
  logic [31:0]     rd_w;
  bta_pkg::addr_t  rd_sz;

  // working registers
  bta_pkg::addr_t  bp_r, bp_nxt, s_r, s_nxt, ps2_r, ps2_nxt, pb_r, pb_nxt;
  bta_pkg::addr_t  nb_r, nb_nxt, nsz_r, nsz_nxt, sum_r, sum_nxt, cur_r, cur_nxt;
  logic            pa_r, pa_nxt, split_r, split_nxt, mode_r, mode_nxt;
  logic            rz_r, rz_nxt;
  logic [bta_pkg::ASZ_W-1:0]   asize_r, asize_nxt;
  logic [bta_pkg::GSZ_W-1:0]   gsz_r, gsz_nxt;
  logic [BW-1:0]               brk_r, brk_nxt;
  logic [bta_pkg::CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [AW-1:0]               clr_r, clr_nxt;
  bta_pkg::out_t               out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // combinational helpers
  bta_pkg::addr_t              asz_a, brk_a, sum_w, pb_w, grow_end;
  logic [bta_pkg::ASZ_W-1:0]   ext, req_asz;
  logic [bta_pkg::GSZ_W-1:0]   gsz_w;
  logic [31:0]                 init_w;
  logic                        split_w;

  assign rd_w  = rd_oob_r ? bta_pkg::ALLOC_TAG : q_r;
  assign rd_sz = bta_pkg::size_of(rd_w);
  assign asz_a = bta_pkg::ADDR_W'(asize_r);
  assign brk_a = bta_pkg::ADDR_W'(brk_r);
  assign r_idx = raddr[AW+1:2];
  assign w_idx = waddr[AW+1:2];
  assign mem_we = wreq && (waddr < HEAP_BYTES);

  // request rounded to an aligned block with header and footer
  assign req_asz = (in_data.request_bytes <= bta_pkg::REQ_W'(bta_pkg::ALIGN_BYTES))
                 ? bta_pkg::ASZ_W'(bta_pkg::MIN_BLOCK)
                 : ((bta_pkg::ASZ_W'(in_data.request_bytes) + bta_pkg::ASZ_W'(15))
                    & ~bta_pkg::ASZ_W'(7));

  // growth size: max of block and chunk, rounded to an even word count
  assign ext      = (asize_r > bta_pkg::ASZ_W'(chunk_r)) ? asize_r
                                                         : bta_pkg::ASZ_W'(chunk_r);
  assign gsz_w    = {bta_pkg::GSZ_W'(ext[bta_pkg::ASZ_W-1:3]) + bta_pkg::GSZ_W'(ext[2]),
                     3'b000} [bta_pkg::GSZ_W-1:0];
  assign grow_end = brk_a + bta_pkg::ADDR_W'(gsz_w);

  assign split_w = (rd_sz >= asz_a) && ((rd_sz - asz_a) >= bta_pkg::ADDR_W'(16));
  assign pb_w    = bp_r - rd_sz;

  // reset image of the heap
  always_comb begin
    init_w = '0;
    if (clr_r == AW'(1) || clr_r == AW'(2)) begin
      init_w = bta_pkg::PROLOG_TAG;
    end else if (clr_r == AW'(3)) begin
      init_w = BIG_HEAP ? bta_pkg::INIT_CHUNK : bta_pkg::ALLOC_TAG;
    end else if (BIG_HEAP && 32'(clr_r) == 32'd1026) begin
      init_w = bta_pkg::INIT_CHUNK;
    end else if (BIG_HEAP && 32'(clr_r) == 32'd1027) begin
      init_w = bta_pkg::ALLOC_TAG;
    end
  end

  // status to the sequencer
  always_comb begin
    sts.clr_last   = (32'(clr_r) == 32'(HEAP_WORDS - 1));
    sts.is_free    = mode_r;
    sts.req_zero   = rz_r;
    sts.bp_lt_brk  = (bp_r < brk_a);
    sts.blk_zero   = (rd_sz == '0);
    sts.blk_fit    = !rd_w[0] && (rd_sz >= asz_a);
    sts.grow_ok    = (grow_end <= HEAP_BYTES);
    sts.prev_alloc = pa_r;
    sts.next_alloc = rd_w[0];
    sts.split      = split_r;
  end

  // operation decode
  always_comb begin
    raddr = bp_r - A4;
    waddr = '0;
    wval  = '0;
    wreq  = 1'b0;
    sum_w = s_r + ps2_r;
    bp_nxt = bp_r;   s_nxt = s_r;     ps2_nxt = ps2_r;  pb_nxt = pb_r;
    nb_nxt = nb_r;   nsz_nxt = nsz_r; sum_nxt = sum_r;  cur_nxt = cur_r;
    pa_nxt = pa_r;   split_nxt = split_r; mode_nxt = mode_r; rz_nxt = rz_r;
    asize_nxt = asize_r; gsz_nxt = gsz_r; brk_nxt = brk_r;
    chunk_nxt = cfg_we ? cfg_data : chunk_r;
    clr_nxt   = clr_r;
    out_nxt   = out_r;
    out_valid_nxt = 1'b0;
    case (cmd.op)
      bta_pkg::OP_CLEAR: begin
        waddr   = bta_pkg::ADDR_W'({clr_r, 2'b00});
        wval    = bta_pkg::ADDR_W'(init_w);
        wreq    = 1'b1;
        clr_nxt = clr_r + AW'(1);
      end
      bta_pkg::OP_LOAD: begin
        mode_nxt  = in_data.mode;
        bp_nxt    = bta_pkg::ADDR_W'(in_data.freed_address);
        asize_nxt = req_asz;
        rz_nxt    = (in_data.request_bytes == '0);
      end
      bta_pkg::OP_DISP: begin
        if (!mode_r) bp_nxt = bta_pkg::ADDR_W'(bta_pkg::FIRST_BP);
      end
      // free: clear the allocated bit in header and footer
      bta_pkg::OP_F_WH: begin
        s_nxt = rd_sz;
        waddr = bp_r - A4;
        wval  = rd_sz;
        wreq  = 1'b1;
      end
      bta_pkg::OP_F_WF: begin
        waddr = bp_r + s_r - A8;
        wval  = s_r;
        wreq  = 1'b1;
      end
      // coalesce: gather neighbour tags
      bta_pkg::OP_M_RPF: raddr = bp_r - A8;
      bta_pkg::OP_M_RPH: begin
        pb_nxt = pb_w;
        raddr  = pb_w - A4;
      end
      bta_pkg::OP_M_RPA: begin
        ps2_nxt = rd_sz;
        raddr   = pb_r + rd_sz - A8;
      end
      bta_pkg::OP_M_RH: pa_nxt = rd_w[0];
      bta_pkg::OP_M_RNH: begin
        s_nxt  = rd_sz;
        nb_nxt = bp_r + rd_sz;
        raddr  = bp_r + rd_sz - A4;
      end
      bta_pkg::OP_M_DEC: nsz_nxt = rd_sz;
      // next block free
      bta_pkg::OP_M1_WH: begin
        sum_w   = s_r + nsz_r;
        sum_nxt = sum_w;
        waddr   = bp_r - A4;
        wval    = sum_w;
        wreq    = 1'b1;
      end
      bta_pkg::OP_M1_WF: begin
        waddr = bp_r + rd_sz - A8;
        wval  = sum_r;
        wreq  = 1'b1;
      end
      // previous block free
      bta_pkg::OP_M2_WF: begin
        sum_nxt = sum_w;
        waddr   = bp_r + s_r - A8;
        wval    = sum_w;
        wreq    = 1'b1;
      end
      bta_pkg::OP_M2_RP: raddr = bp_r - A8;
      bta_pkg::OP_M2_WP: begin
        waddr  = pb_w - A4;
        wval   = sum_r;
        wreq   = 1'b1;
        bp_nxt = pb_w;
      end
      // both neighbours free
      bta_pkg::OP_M3_WF: begin
        sum_w   = s_r + ps2_r + nsz_r;
        sum_nxt = sum_w;
        waddr   = nb_r + nsz_r - A8;
        wval    = sum_w;
        wreq    = 1'b1;
      end
      bta_pkg::OP_M3_WP: begin
        waddr  = pb_r - A4;
        wval   = sum_r;
        wreq   = 1'b1;
        bp_nxt = pb_r;
      end
      // first-fit step to the next block
      bta_pkg::OP_A_CHK: begin
        if (!(!rd_w[0] && (rd_sz >= asz_a))) bp_nxt = bp_r + rd_sz;
      end
      // heap growth
      bta_pkg::OP_G_CALC: begin
        gsz_nxt = gsz_w;
        if (grow_end <= HEAP_BYTES) begin
          bp_nxt  = brk_a;
          brk_nxt = grow_end[BW-1:0];
        end
      end
      bta_pkg::OP_G_WH: begin
        waddr = bp_r - A4;
        wval  = bta_pkg::ADDR_W'(gsz_r);
        wreq  = 1'b1;
      end
      bta_pkg::OP_G_WF: begin
        waddr = bp_r + bta_pkg::ADDR_W'(gsz_r) - A8;
        wval  = bta_pkg::ADDR_W'(gsz_r);
        wreq  = 1'b1;
      end
      bta_pkg::OP_G_WE: begin
        waddr = bp_r + bta_pkg::ADDR_W'(gsz_r) - A4;
        wval  = bta_pkg::ADDR_W'(bta_pkg::ALLOC_TAG);
        wreq  = 1'b1;
      end
      // placement with optional split
      bta_pkg::OP_P_W1: begin
        cur_nxt   = rd_sz;
        split_nxt = split_w;
        waddr     = bp_r - A4;
        wval      = (split_w ? asz_a : rd_sz) | bta_pkg::ADDR_W'(1);
        wreq      = 1'b1;
      end
      bta_pkg::OP_P_W2: begin
        waddr  = bp_r + rd_sz - A8;
        wval   = (split_r ? asz_a : cur_r) | bta_pkg::ADDR_W'(1);
        wreq   = 1'b1;
        nb_nxt = bp_r + rd_sz;
      end
      bta_pkg::OP_P_W3: begin
        waddr = nb_r - A4;
        wval  = cur_r - asz_a;
        wreq  = 1'b1;
      end
      bta_pkg::OP_P_RN: raddr = nb_r - A4;
      bta_pkg::OP_P_W4: begin
        waddr = nb_r + rd_sz - A8;
        wval  = cur_r - asz_a;
        wreq  = 1'b1;
      end
      bta_pkg::OP_RES: begin
        out_nxt.status          = cmd.stat;
        out_nxt.payload_address = (cmd.stat == bta_pkg::ST_DONE && !mode_r)
                                ? bp_r[bta_pkg::FREE_W-1:0] : '0;
        out_valid_nxt           = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // store port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[w_idx] <= wval[31:0];
    q_r      <= mem[r_idx];
    rd_oob_r <= !(raddr < HEAP_BYTES);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brk_r       <= BW'(BRK_RESET);
      chunk_r     <= bta_pkg::CHUNK_RESET;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      brk_r       <= brk_nxt;
      chunk_r     <= chunk_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    bp_r <= bp_nxt;   s_r <= s_nxt;     ps2_r <= ps2_nxt;  pb_r <= pb_nxt;
    nb_r <= nb_nxt;   nsz_r <= nsz_nxt; sum_r <= sum_nxt;  cur_r <= cur_nxt;
    pa_r <= pa_nxt;   split_r <= split_nxt; mode_r <= mode_nxt; rz_r <= rz_nxt;
    asize_r <= asize_nxt; gsz_r <= gsz_nxt; out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // the heap break only moves up
  a_brk_up: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> brk_r >= $past(brk_r))
    else $error("heap break moved down");

  // the break stays aligned and inside the store
  a_brk_ok: assert property (@(posedge clk) disable iff (!rst_n)
    brk_r[2:0] == 3'b000 && bta_pkg::ADDR_W'(brk_r) <= HEAP_BYTES)
    else $error("heap break misaligned or past store");

  // no store write without an operation
  a_no_stray_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == bta_pkg::OP_NONE |-> !mem_we)
    else $error("store written while idle");
`endif

endmodule
